### rtl/rfbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfbr_pkg;

    // Field widths that the item layout fixes.
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 8;
    localparam int TOTAL_W = 32;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_READ      = 2'd1;
    localparam logic [1:0] KIND_CLEAR     = 2'd2;
    localparam logic [1:0] KIND_CLEAR_ALL = 2'd3;

    // Status codes reported with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_SKIP  = 2'd3;

    // One command item.
    typedef struct packed {
        logic [1:0]         kind;
        logic               block_first;
        logic               block_last;
        logic [VALUE_W-1:0] value_a;
        logic [VALUE_W-1:0] value_b;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] read_a;
        logic [VALUE_W-1:0] read_b;
        logic [COUNT_W-1:0] stored_count;
        logic               is_empty;
        logic               is_full;
        logic [TOTAL_W-1:0] total_reads;
        logic [TOTAL_W-1:0] total_writes;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/rfbr_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rfbr_mem #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 16
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire  [DATA_WIDTH-1:0]        wr_data,
    input  wire                          rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0]        rd_data
);

    logic [DATA_WIDTH-1:0] slot_mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/ring_fifo_block_rollback.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring FIFO with block rollback. A command item is taken when start is high and
// busy is low; its result appears on result, marked by done for a single cycle,
// and the receiver cannot hold it off. Writes without pair mode, failed
// or skipped elements and clears need no further state: done follows in the
// next cycle, and a new item can be taken in that same cycle, so such items
// run at one per clock. A pair-mode write passes through ST_WR2, a read
// through ST_RD_A and a pair-mode read through ST_RD_A and ST_RD_B, with busy
// high, because the slot memory has one write port and one read port with
// registered read data and each value needs one access. The slot memory has
// no reset and is never cleared; reading a slot that was never written returns
// whatever it holds. Configuration writes are taken whenever busy is low.
module ring_fifo_block_rollback #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire rfbr_pkg::in_item_t item,
    output logic                 done,
    output rfbr_pkg::out_item_t  result,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_XW = (PTR_W > rfbr_pkg::COUNT_W) ? PTR_W : rfbr_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PAIR_FULL_USED = PTR_W'(DEPTH - 2);
    localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WR2  = 4'b0010,
        ST_RD_A = 4'b0100,
        ST_RD_B = 4'b1000
    } state_t;

    // Pointer step with wrap at the end of the ring.
    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // Used slots between head and tail, modulo the depth.
    function automatic logic [PTR_W-1:0] used_of(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t);
        logic [PTR_W:0] tmp;
        tmp = {1'b0, t} + ((t < h) ? DEPTH_X : '0) - {1'b0, h};
        return tmp[PTR_W-1:0];
    endfunction

    // No room for one more element.
    function automatic logic full_of(input logic [PTR_W-1:0] used, input logic pair);
        return pair ? (used >= PAIR_FULL_USED) : (used == LAST_PTR);
    endfunction

    // Not enough data for one element.
    function automatic logic short_of(input logic [PTR_W-1:0] used, input logic pair);
        return pair ? (used < PTR_W'(2)) : (used == '0);
    endfunction

    state_t                               state_reg, state_next;
    logic [PTR_W-1:0]                     head_reg, head_next;
    logic [PTR_W-1:0]                     tail_reg, tail_next;
    logic [PTR_W-1:0]                     ckpt_reg, ckpt_next;
    logic                                 failed_reg, failed_next;
    logic [rfbr_pkg::TOTAL_W-1:0]         rd_total_reg, rd_total_next;
    logic [rfbr_pkg::TOTAL_W-1:0]         wr_total_reg, wr_total_next;
    logic                                 pair_reg, pair_next;
    logic                                 done_reg, done_next;
    rfbr_pkg::out_item_t                  res_reg, res_next;
    logic [DATA_WIDTH-1:0]                wr_b_reg, wr_b_next;
    logic [PTR_W-1:0]                     addr2_reg, addr2_next;

    logic                                 accept;
    logic                                 is_clear;
    logic [PTR_W-1:0]                     used_now;
    logic [PTR_W-1:0]                     used_after;
    logic [CNT_XW-1:0]                    used_wide;
    logic [CNT_XW-1:0]                    used_half;
    logic [PTR_W-1:0]                     cp_eff;
    logic [1:0]                           op_status;
    logic                                 load_res;
    logic                                 cap_a;
    logic                                 cap_b;

    logic                                 mem_we;
    logic [PTR_W-1:0]                     mem_waddr;
    logic [DATA_WIDTH-1:0]                mem_wdata;
    logic                                 mem_re;
    logic [PTR_W-1:0]                     mem_raddr;
    logic [DATA_WIDTH-1:0]                mem_rdata;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign is_clear  = (item.kind == rfbr_pkg::KIND_CLEAR) ||
                       (item.kind == rfbr_pkg::KIND_CLEAR_ALL);
    assign used_now  = used_of(head_reg, tail_reg);
    assign cp_eff    = item.block_first
                       ? ((item.kind == rfbr_pkg::KIND_WRITE) ? tail_reg : head_reg)
                       : ckpt_reg;

    // Slot storage.
    rfbr_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Command sequencer: pointer updates, memory accesses and rollback.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ckpt_next     = ckpt_reg;
        failed_next   = failed_reg;
        rd_total_next = rd_total_reg;
        wr_total_next = wr_total_reg;
        pair_next     = pair_reg;
        done_next     = 1'b0;
        wr_b_next     = wr_b_reg;
        addr2_next    = addr2_reg;
        op_status     = rfbr_pkg::STATUS_OK;
        load_res      = 1'b0;
        cap_a         = 1'b0;
        cap_b         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = tail_reg;
        mem_wdata     = DATA_WIDTH'(item.value_a);
        mem_re        = 1'b0;
        mem_raddr     = head_reg;

        if (cfg_valid && cfg_ready)
        begin
            pair_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_res = 1'b1;
                    if (is_clear)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        ckpt_next   = '0;
                        failed_next = 1'b0;
                        if (item.kind == rfbr_pkg::KIND_CLEAR_ALL)
                        begin
                            rd_total_next = '0;
                            wr_total_next = '0;
                        end
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (item.block_first)
                        begin
                            ckpt_next   = cp_eff;
                            failed_next = 1'b0;
                        end
                        if (!item.block_first && failed_reg)
                        begin
                            // Rest of a failed block is skipped.
                            op_status = rfbr_pkg::STATUS_SKIP;
                            if (item.block_last)
                            begin
                                failed_next = 1'b0;
                            end
                            done_next = 1'b1;
                        end
                        else if (item.kind == rfbr_pkg::KIND_WRITE)
                        begin
                            if (full_of(used_now, pair_reg))
                            begin
                                tail_next   = cp_eff;
                                op_status   = rfbr_pkg::STATUS_FULL;
                                failed_next = !item.block_last;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                tail_next     = adv(tail_reg);
                                wr_total_next = wr_total_reg + 1'b1;
                                if (pair_reg)
                                begin
                                    addr2_next = adv(tail_reg);
                                    tail_next  = adv(adv(tail_reg));
                                    wr_b_next  = DATA_WIDTH'(item.value_b);
                                    state_next = ST_WR2;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (short_of(used_now, pair_reg))
                            begin
                                head_next   = cp_eff;
                                op_status   = rfbr_pkg::STATUS_EMPTY;
                                failed_next = !item.block_last;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                head_next     = adv(head_reg);
                                rd_total_next = rd_total_reg + 1'b1;
                                addr2_next    = adv(head_reg);
                                if (pair_reg)
                                begin
                                    head_next = adv(adv(head_reg));
                                end
                                state_next = ST_RD_A;
                            end
                        end
                    end
                end
            end
            ST_WR2:
            begin
                // Second value of a pair goes into the next slot.
                mem_we     = 1'b1;
                mem_waddr  = addr2_reg;
                mem_wdata  = wr_b_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_A:
            begin
                cap_a = 1'b1;
                if (pair_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr2_reg;
                    state_next = ST_RD_B;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_B:
            begin
                cap_b      = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Status fields follow the pointers after the step.
    assign used_after = used_of(head_next, tail_next);
    assign used_wide  = CNT_XW'(used_after);
    assign used_half  = used_wide >> 1;

    // Result register.
    always_comb
    begin
        res_next = res_reg;
        if (load_res)
        begin
            res_next.status       = op_status;
            res_next.read_a       = '0;
            res_next.read_b       = '0;
            res_next.stored_count = pair_reg ? used_half[rfbr_pkg::COUNT_W-1:0]
                                             : used_wide[rfbr_pkg::COUNT_W-1:0];
            res_next.is_empty     = (head_next == tail_next);
            res_next.is_full      = full_of(used_after, pair_reg);
            res_next.total_reads  = rd_total_next;
            res_next.total_writes = wr_total_next;
        end
        if (cap_a)
        begin
            res_next.read_a = rfbr_pkg::VALUE_W'(mem_rdata);
        end
        if (cap_b)
        begin
            res_next.read_b = rfbr_pkg::VALUE_W'(mem_rdata);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            ckpt_reg     <= '0;
            failed_reg   <= 1'b0;
            rd_total_reg <= '0;
            wr_total_reg <= '0;
            pair_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            ckpt_reg     <= ckpt_next;
            failed_reg   <= failed_next;
            rd_total_reg <= rd_total_next;
            wr_total_reg <= wr_total_next;
            pair_reg     <= pair_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        wr_b_reg  <= wr_b_next;
        addr2_reg <= addr2_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // Pointers always stay inside the ring, also for depths that are not powers of two.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < DEPTH_X) && ({1'b0, tail_reg} < DEPTH_X) &&
        ({1'b0, ckpt_reg} < DEPTH_X))
        else $error("ring pointer out of range");

    // A clear reports done in the next cycle and leaves the ring empty.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_clear) |=> (done && result.is_empty &&
                                           (result.stored_count == '0)))
        else $error("clear did not report an empty ring");

    // An empty ring never reports a nonzero count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.stored_count == '0))
        else $error("empty ring with nonzero count");

    // Only a successful operation carries read data.
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != rfbr_pkg::STATUS_OK)) |->
        ((result.read_a == '0) && (result.read_b == '0)))
        else $error("read data on a failed or skipped item");

endmodule

`default_nettype wire
